>>> design/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants for the per-source packet rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int unsigned ENTRIES_DEF = 256;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned COUNT_W     = 24;
  localparam int unsigned TIME_W      = 31;
  localparam int unsigned REM_W       = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0] RATE_LIMIT_RST = 24'd1000;
  localparam logic [TIME_W-1:0]  EXPIRY_RST     = 31'd600;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [REM_W-1:0]   REMOVED_MAX    = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY     = 1'b1;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PKT_DONE,
    ST_SWP_RD,
    ST_SWP_CHK,
    ST_SWP_DONE
  } psrl_state_t;

  typedef struct packed {
    logic load;       // capture the item
    logic idx_clr;    // index to zero
    logic idx_inc;    // advance index
    logic rd;         // read entry at index
    logic pkt_eval;   // evaluate hit/free on read data
    logic pkt_commit; // write packet update
    logic swp_commit; // write sweep update
    logic emit;       // drive result strobe
  } psrl_cmd_t;

  typedef struct packed {
    logic op;
    logic idx_last;
    logic hit;
  } psrl_sts_t;

endpackage

>>> design/psrl_ctrl.sv
// ----------------------------------------------------------------------------
// psrl_ctrl
// Sequencer for table scans: packet lookup and expiry sweep.
// ----------------------------------------------------------------------------
module psrl_ctrl import psrl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  psrl_sts_t sts,
  output psrl_cmd_t cmd
);

  psrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = (sts.op == OP_SWEEP) ? ST_SWP_CHK : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cmd.pkt_eval = 1'b1;
        if (sts.hit || sts.idx_last) begin
          state_nxt = ST_PKT_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd      = 1'b1;
        end
      end
      ST_PKT_DONE: begin
        cmd.pkt_commit = 1'b1;
        cmd.emit       = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SWP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SWP_CHK;
      end
      ST_SWP_CHK: begin
        cmd.swp_commit = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_SWP_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SWP_RD;
        end
      end
      ST_SWP_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> design/psrl_dp.sv
// ----------------------------------------------------------------------------
// psrl_dp
// Entry memories, valid bits, scan index and result registers.
// ----------------------------------------------------------------------------
module psrl_dp import psrl_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psrl_cmd_t            cmd,
  output psrl_sts_t            sts,
  input  logic                 in_opcode,
  input  logic [ADDR_W-1:0]    in_src_addr,
  input  logic [TIME_W-1:0]    in_now_seconds,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                 out_valid,
  output logic                 out_over_limit,
  output logic [COUNT_W-1:0]   out_packet_count,
  output logic                 out_table_full,
  output logic [REM_W-1:0]     out_removed_count
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic [ADDR_W-1:0]  addr_mem  [ENTRIES];
  logic [COUNT_W-1:0] count_mem [ENTRIES];
  logic [TIME_W-1:0]  first_mem [ENTRIES];
  logic [TIME_W-1:0]  last_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [COUNT_W-1:0] rate_limit_r;
  logic [TIME_W-1:0]  expiry_r;
  logic               op_r;
  logic [ADDR_W-1:0]  src_r;
  logic [TIME_W-1:0]  now_r;
  logic [IDX_W-1:0]   idx_r, rd_idx_r;

  logic [ADDR_W-1:0]  rd_addr_r;
  logic [COUNT_W-1:0] rd_count_r;
  logic [TIME_W-1:0]  rd_first_r, rd_last_r;
  logic               rd_valid_r;

  logic               hit_r, free_found_r;
  logic [IDX_W-1:0]   hit_idx_r, free_idx_r;
  logic [COUNT_W-1:0] hit_count_r;
  logic [REM_W-1:0]   removed_r;

  logic               cur_hit;
  logic               first_old, last_old;
  logic [TIME_W:0]    age_first, age_last;
  logic [COUNT_W-1:0] inc_count;

  assign cur_hit      = rd_valid_r && (rd_addr_r == src_r);
  assign sts.op       = op_r;
  assign sts.idx_last = (idx_r == IDX_W'(ENTRIES - 1));
  assign sts.hit      = cur_hit;

  assign age_first = {1'b0, now_r} - {1'b0, rd_first_r};
  assign age_last  = {1'b0, now_r} - {1'b0, rd_last_r};
  assign first_old = !age_first[TIME_W] && (age_first[TIME_W-1:0] > expiry_r);
  assign last_old  = !age_last[TIME_W]  && (age_last[TIME_W-1:0]  > expiry_r);
  assign inc_count = (hit_count_r == COUNT_MAX) ? hit_count_r : hit_count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r <= RATE_LIMIT_RST;
      expiry_r     <= EXPIRY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RATE_LIMIT: rate_limit_r <= cfg_data[COUNT_W-1:0];
        CFG_EXPIRY:     expiry_r     <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      src_r <= in_src_addr;
      now_r <= in_now_seconds;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.rd) begin
      rd_idx_r   <= cmd.idx_inc ? idx_r + 1'b1 : idx_r;
      rd_addr_r  <= addr_mem[cmd.idx_inc ? idx_r + 1'b1 : idx_r];
      rd_count_r <= count_mem[cmd.idx_inc ? idx_r + 1'b1 : idx_r];
      rd_first_r <= first_mem[cmd.idx_inc ? idx_r + 1'b1 : idx_r];
      rd_last_r  <= last_mem[cmd.idx_inc ? idx_r + 1'b1 : idx_r];
      rd_valid_r <= valid_r[cmd.idx_inc ? idx_r + 1'b1 : idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      removed_r    <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.load) begin
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
        removed_r    <= '0;
      end
      if (cmd.pkt_eval) begin
        if (cur_hit) begin
          hit_r       <= 1'b1;
          hit_idx_r   <= rd_idx_r;
          hit_count_r <= rd_count_r;
        end
        if (!rd_valid_r && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
        end
      end
      if (cmd.pkt_commit && !hit_r && free_found_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.swp_commit && rd_valid_r && last_old) begin
        valid_r[rd_idx_r] <= 1'b0;
        if (removed_r != REMOVED_MAX) begin
          removed_r <= removed_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pkt_commit) begin
      if (hit_r) begin
        count_mem[hit_idx_r] <= inc_count;
        last_mem[hit_idx_r]  <= now_r;
      end else if (free_found_r) begin
        addr_mem[free_idx_r]  <= src_r;
        count_mem[free_idx_r] <= COUNT_W'(1);
        first_mem[free_idx_r] <= now_r;
        last_mem[free_idx_r]  <= now_r;
      end
    end
    if (cmd.swp_commit && rd_valid_r && first_old) begin
      count_mem[rd_idx_r] <= '0;
      first_mem[rd_idx_r] <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (op_r == OP_SWEEP) begin
        out_over_limit    <= 1'b0;
        out_packet_count  <= '0;
        out_table_full    <= 1'b0;
        out_removed_count <= removed_r;
      end else if (hit_r) begin
        out_over_limit    <= inc_count > rate_limit_r;
        out_packet_count  <= inc_count;
        out_table_full    <= 1'b0;
        out_removed_count <= '0;
      end else if (free_found_r) begin
        out_over_limit    <= COUNT_W'(1) > rate_limit_r;
        out_packet_count  <= COUNT_W'(1);
        out_table_full    <= 1'b0;
        out_removed_count <= '0;
      end else begin
        out_over_limit    <= 1'b0;
        out_packet_count  <= '0;
        out_table_full    <= 1'b1;
        out_removed_count <= '0;
      end
    end
  end

endmodule

>>> design/per_source_packet_rate_limiter.sv
// Packet lookup: scans entries one per cycle until a hit or the last entry.
// Sweep: each entry is read, then checked and written back, through the single read port.
// Result strobe out_valid is registered from the emit of the done state after the last scan step; busy holds meanwhile.
// A new item is taken only in idle, after the last one is through; start is taken in the same cycle as out_valid.
// Synchronous active-low reset clears valid bits and loads default limits.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
// per_source_packet_rate_limiter
// Top level: source table with rate counting and expiry sweep.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter import psrl_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [ADDR_W-1:0]     in_src_addr,
  input  logic [TIME_W-1:0]     in_now_seconds,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic                  out_over_limit,
  output logic [COUNT_W-1:0]    out_packet_count,
  output logic                  out_table_full,
  output logic [REM_W-1:0]      out_removed_count
);

  psrl_cmd_t cmd;
  psrl_sts_t sts;

  assign cfg_ready = 1'b1;

  psrl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  psrl_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_src_addr       (in_src_addr),
    .in_now_seconds    (in_now_seconds),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_over_limit    (out_over_limit),
    .out_packet_count  (out_packet_count),
    .out_table_full    (out_table_full),
    .out_removed_count (out_removed_count)
  );

endmodule
